@@ hw/rtl/mecpd_pkg.sv @@
// Shared types and constants of the multi-encoding code point decoder.
// No dependencies; used by the channel interfaces, the decoder and its checker.
`default_nettype none

package mecpd_pkg;

	// Encoding selected by the mode register
	typedef enum logic [2:0] {
		MODE_UTF8     = 3'd0,
		MODE_UCS2_BE  = 3'd1,
		MODE_UCS2_LE  = 3'd2,
		MODE_UTF16_BE = 3'd3,
		MODE_UTF16_LE = 3'd4,
		MODE_UTF32_BE = 3'd5,
		MODE_UTF32_LE = 3'd6,
		MODE_SINGLE   = 3'd7
	} mode_t;

	// Error code carried with each result
	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_STRAY_CONT = 3'd1,
		ERR_BAD_LEAD   = 3'd2,
		ERR_MISS_CONT  = 3'd3,
		ERR_UCS2_SURR  = 3'd4,
		ERR_BAD_HIGH   = 3'd5,
		ERR_MISS_LOW   = 3'd6,
		ERR_TRUNCATED  = 3'd7
	} err_t;

	// Register map
	localparam int unsigned  ADDR_W        = 3;
	localparam logic         REG_IDX_MODE  = 1'b0;

	// Surrogate arithmetic
	localparam logic [20:0]  SUPP_BASE     = 21'h10000;

endpackage

`default_nettype wire

@@ hw/rtl/mecpd_ifs.sv @@
// Valid/ready channel interfaces: raw byte stream in, decoded characters out.
// Depends on mecpd_pkg.
`default_nettype none

interface mecpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mecpd_char_if;
	import mecpd_pkg::*;
	logic        valid;
	logic        ready;
	logic [31:0] code_point;
	logic        is_blank;
	err_t        error_code;

	modport source (output valid, code_point, is_blank, error_code, input ready);
	modport sink   (input valid, code_point, is_blank, error_code, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/multi_encoding_code_point_decoder.sv @@
// Multi-encoding code point decoder: byte stream to code points, APB mode register.
// Depends on mecpd_pkg and the channel interfaces in mecpd_ifs.sv.
//
//   channel       kind        payload
//   byte_stream   sink        data_byte[7:0], last_byte
//   char_stream   source      code_point[31:0], is_blank, error_code[2:0]
//   apb           slave       encoding_mode at byte address 0
//
// One byte per cycle sustained while char_stream does not stall. A byte is
// held in the input register, and its result (if any) is loaded into the
// result register when the byte advances. The decode step between the two
// registers sets the rate. A stall on char_stream holds the result and backs
// up into byte_stream once the input register is full. Reset sets the mode
// to UTF-8; a mode write sets the written mode. Both drop any partial character.
`default_nettype none

module multi_encoding_code_point_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mecpd_byte_if.sink                         byte_stream,
	mecpd_char_if.source                       char_stream,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mecpd_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);
	import mecpd_pkg::*;

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Mode and character state
	mode_t       mode_q;
	logic [31:0] part_q;
	logic [1:0]  seen_q;
	logic [2:0]  explen_q;
	logic [9:0]  high_q;
	logic        await_q;

	// Result register
	logic        out_valid_q;
	logic [31:0] cp_q;
	logic        blank_q;
	err_t        err_q;

	// Next state and result of the decode step
	logic [31:0] nxt_part;
	logic [1:0]  nxt_seen;
	logic [2:0]  nxt_explen;
	logic [9:0]  nxt_high;
	logic        nxt_await;
	logic        res_fire;
	logic [31:0] res_cp;
	err_t        res_err;
	logic        res_blank;
	logic        chk_trunc;
	logic [15:0] unit;
	logic [20:0] utf8_acc;
	logic [2:0]  utf8_cnt;
	logic [2:0]  u32_cnt;
	logic [31:0] u32_acc;
	logic [20:0] supp_cp;

	logic        advance;
	logic        cfg_wr;

	// Handshakes
	assign advance           = valid_s1 && (!out_valid_q || char_stream.ready);
	assign byte_stream.ready = !valid_s1 || advance;
	assign cfg_wr            = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_MODE);

	// APB
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_MODE) ? {29'd0, mode_q} : 32'd0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.ready && byte_stream.valid) begin
			byte_s1 <= byte_stream.data_byte;
			last_s1 <= byte_stream.last_byte;
		end
	end

	// Datapath helpers
	always_comb begin
		if (mode_q == MODE_UCS2_BE || mode_q == MODE_UTF16_BE) begin
			unit = {part_q[7:0], byte_s1};
		end else begin
			unit = {byte_s1, part_q[7:0]};
		end
		utf8_acc = {part_q[14:0], byte_s1[5:0]};
		utf8_cnt = {1'b0, seen_q} + 3'd1;
		u32_cnt  = {1'b0, seen_q} + 3'd1;
		if (mode_q == MODE_UTF32_BE) begin
			u32_acc = {part_q[23:0], byte_s1};
		end else begin
			u32_acc = {byte_s1, part_q[31:8]};
		end
		supp_cp = {1'b0, high_q, unit[9:0]} + SUPP_BASE;
	end

	// Decode step
	always_comb begin
		nxt_part   = part_q;
		nxt_seen   = seen_q;
		nxt_explen = explen_q;
		nxt_high   = high_q;
		nxt_await  = await_q;
		res_fire   = 1'b0;
		res_cp     = 32'd0;
		res_err    = ERR_NONE;
		chk_trunc  = 1'b0;

		case (mode_q)
			MODE_UTF8: begin
				if (explen_q == 3'd0) begin
					if (!byte_s1[7]) begin
						res_fire = 1'b1;
						res_cp   = {24'd0, byte_s1};
					end else if (byte_s1[7:6] == 2'b10) begin
						res_fire = 1'b1;
						res_err  = ERR_STRAY_CONT;
					end else if (byte_s1[7:5] == 3'b110) begin
						nxt_part   = {27'd0, byte_s1[4:0]};
						nxt_explen = 3'd2;
						nxt_seen   = 2'd1;
						chk_trunc  = 1'b1;
					end else if (byte_s1[7:4] == 4'b1110) begin
						nxt_part   = {28'd0, byte_s1[3:0]};
						nxt_explen = 3'd3;
						nxt_seen   = 2'd1;
						chk_trunc  = 1'b1;
					end else if (byte_s1[7:3] == 5'b11110) begin
						nxt_part   = {29'd0, byte_s1[2:0]};
						nxt_explen = 3'd4;
						nxt_seen   = 2'd1;
						chk_trunc  = 1'b1;
					end else begin
						res_fire = 1'b1;
						res_err  = ERR_BAD_LEAD;
					end
				end else if (byte_s1[7:6] != 2'b10) begin
					res_fire = 1'b1;
					res_err  = ERR_MISS_CONT;
				end else if (utf8_cnt >= explen_q) begin
					res_fire = 1'b1;
					res_cp   = {11'd0, utf8_acc};
				end else begin
					nxt_part  = {11'd0, utf8_acc};
					nxt_seen  = utf8_cnt[1:0];
					chk_trunc = 1'b1;
				end
			end
			MODE_UCS2_BE, MODE_UCS2_LE, MODE_UTF16_BE, MODE_UTF16_LE: begin
				if (seen_q == 2'd0) begin
					nxt_part  = {24'd0, byte_s1};
					nxt_seen  = 2'd1;
					chk_trunc = 1'b1;
				end else begin
					nxt_part = 32'd0;
					nxt_seen = 2'd0;
					if (mode_q == MODE_UCS2_BE || mode_q == MODE_UCS2_LE) begin
						res_fire = 1'b1;
						if (unit inside {[16'hD800:16'hDFFF]}) begin
							res_err = ERR_UCS2_SURR;
						end else begin
							res_cp = {16'd0, unit};
						end
					end else if (await_q) begin
						res_fire = 1'b1;
						if (unit[15:10] == 6'b110111) begin
							res_cp = {11'd0, supp_cp};
						end else begin
							res_err = ERR_MISS_LOW;
						end
					end else if (unit[15:11] != 5'b11011) begin
						res_fire = 1'b1;
						res_cp   = {16'd0, unit};
					end else if (unit[15:10] == 6'b110110) begin
						// high surrogate: keep it and wait for the low unit
						nxt_high  = unit[9:0];
						nxt_await = 1'b1;
						chk_trunc = 1'b1;
					end else begin
						res_fire = 1'b1;
						res_err  = ERR_BAD_HIGH;
					end
				end
			end
			MODE_UTF32_BE, MODE_UTF32_LE: begin
				if (u32_cnt >= 3'd4) begin
					res_fire = 1'b1;
					res_cp   = u32_acc;
				end else begin
					nxt_part  = u32_acc;
					nxt_seen  = u32_cnt[1:0];
					chk_trunc = 1'b1;
				end
			end
			default: begin
				res_fire = 1'b1;
				res_cp   = {24'd0, byte_s1};
			end
		endcase

		// Truncation at the end of the buffer
		if (chk_trunc && last_s1 &&
		    (nxt_explen != 3'd0 || nxt_seen != 2'd0 || nxt_await)) begin
			res_fire = 1'b1;
			res_err  = ERR_TRUNCATED;
		end

		// Any result closes the character
		if (res_fire) begin
			nxt_part   = 32'd0;
			nxt_seen   = 2'd0;
			nxt_explen = 3'd0;
			nxt_high   = 10'd0;
			nxt_await  = 1'b0;
		end
	end

	// Blank flag from the fixed list of spaces
	always_comb begin
		res_blank = 1'b0;
		if (res_err == ERR_NONE) begin
			res_blank = (res_cp == 32'h20) || (res_cp == 32'hA0) || (res_cp == 32'h1680) ||
			            (res_cp inside {[32'h2000:32'h200A]}) || (res_cp == 32'h202F) ||
			            (res_cp == 32'h205F) || (res_cp == 32'h3000);
		end
	end

	// Mode register and character state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_UTF8;
			part_q   <= 32'd0;
			seen_q   <= 2'd0;
			explen_q <= 3'd0;
			high_q   <= 10'd0;
			await_q  <= 1'b0;
		end else if (cfg_wr) begin
			mode_q   <= mode_t'(pwdata[2:0]);
			part_q   <= 32'd0;
			seen_q   <= 2'd0;
			explen_q <= 3'd0;
			high_q   <= 10'd0;
			await_q  <= 1'b0;
		end else if (advance) begin
			part_q   <= nxt_part;
			seen_q   <= nxt_seen;
			explen_q <= nxt_explen;
			high_q   <= nxt_high;
			await_q  <= nxt_await;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_fire;
		end else if (char_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_fire) begin
			cp_q    <= res_cp;
			blank_q <= res_blank;
			err_q   <= res_err;
		end
	end

	assign char_stream.valid      = out_valid_q;
	assign char_stream.code_point = cp_q;
	assign char_stream.is_blank   = blank_q;
	assign char_stream.error_code = err_q;

endmodule

`default_nettype wire

@@ hw/rtl/mecpd_checker.sv @@
// Port-level checker for the decoder, attached to the top level by bind.
// Depends on mecpd_pkg and multi_encoding_code_point_decoder.
`default_nettype none

module mecpd_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [31:0]           code_point,
	input wire logic                  is_blank,
	input wire mecpd_pkg::err_t       error_code
);
	import mecpd_pkg::*;

	// A stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point) &&
		$stable(is_blank) && $stable(error_code))
	else $error("result changed while stalled");

	// An error result carries no code point and no blank flag
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> code_point == 32'd0 && !is_blank)
	else $error("error result with nonzero payload");

	// A blank flag only on a code point from 0x20 to 0x3000, the span of the listed spaces
	a_blank_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_blank |-> code_point <= 32'h3000 && code_point >= 32'h20)
	else $error("blank flag on a code point outside the list");

	// A fresh result comes from a byte transfer that went into the input
	// register and from there into the result register
	a_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
	else $error("result without a preceding byte transfer");

endmodule

bind multi_encoding_code_point_decoder mecpd_checker u_mecpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (byte_stream.valid),
	.in_ready   (byte_stream.ready),
	.out_valid  (char_stream.valid),
	.out_ready  (char_stream.ready),
	.code_point (char_stream.code_point),
	.is_blank   (char_stream.is_blank),
	.error_code (char_stream.error_code)
);

`default_nettype wire
